### hw/rtl/aik_pkg.sv
`default_nettype none
package aik_pkg;

    // CORDIC iteration count and datapath widths
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int CW            = 36;   // CORDIC x/y width
    localparam int AW            = 33;   // internal angle width, pi/2^31 units
    localparam int SQ_IN_W       = 64;
    localparam int SQ_OUT_W      = 32;
    localparam int SQ_WORK_W     = 66;
    localparam int DW            = 34;   // divider operand width
    localparam int QW            = 31;   // Q30 quotient width
    localparam int NW            = 35;   // law-of-cosines numerator width
    localparam int SUM_W         = 36;   // final angle sums

    localparam int LAT_SQRT   = SQ_OUT_W;
    localparam int LAT_DIV    = QW;
    localparam int LAT_CORDIC = CORDIC_STAGES + 1;

    localparam logic signed [AW-1:0] ANG_HALF_PI = 33'sd1073741824;
    localparam logic signed [SUM_W-1:0] SUM_HALF_PI = 36'sd1073741824;
    localparam logic signed [SUM_W-1:0] SUM_PI      = 36'sd2147483648;
    localparam logic signed [SUM_W-1:0] ROUND_HALF  = 36'sd32768;
    localparam logic signed [SUM_W-1:0] SAT_HI      = 36'sd65535;
    localparam logic signed [SUM_W-1:0] SAT_LO      = -36'sd65536;
    localparam logic [SQ_IN_W-1:0] Q60_ONE = 64'h1000_0000_0000_0000;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_UPPER  = 2'd0;
    localparam logic [1:0] REG_MIDDLE = 2'd1;
    localparam logic [1:0] REG_FORE   = 2'd2;

    // Rounded arctangent of 2^-i, pi/2^31 units
    localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               hand;
    } side_t;

    typedef struct packed {
        logic signed [NW-1:0] n_t;
        logic signed [NW-1:0] n_a;
    } num_t;

    typedef struct packed {
        logic neg_t;
        logic neg_a;
    } sign_t;

    typedef struct packed {
        logic signed [31:0] c_t;
        logic signed [31:0] c_a;
    } cos_t;

    // Round to pi/32768 and saturate to 17 bits
    function automatic logic signed [16:0] finish_ang(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] w;
        w = (v + ROUND_HALF) >>> 16;
        if (w > SAT_HI)
            finish_ang = 17'sh0FFFF;
        else if (w < SAT_LO)
            finish_ang = 17'sh10000;
        else
            finish_ang = w[16:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/aik_isqrt.sv
`default_nettype none
module aik_isqrt import aik_pkg::*;
(
    input  wire logic                clk,
    input  wire logic [SQ_IN_W-1:0]  rad,
    output logic      [SQ_OUT_W-1:0] root
);

    logic [SQ_WORK_W-1:0] rem_reg  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0]  root_reg [SQ_OUT_W];

    // One result bit per stage, most significant first
    for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
        logic [SQ_WORK_W-1:0] rem_in;
        logic [SQ_WORK_W-1:0] trial;
        logic [SQ_OUT_W-1:0]  root_in;
        logic [SQ_WORK_W-1:0] rem_next;
        logic [SQ_OUT_W-1:0]  root_next;

        if (k == 0) begin : g_first
            assign rem_in  = SQ_WORK_W'(rad);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign trial = (SQ_WORK_W'(root_in) << (SQ_OUT_W - k))
                     + (SQ_WORK_W'(1) << (2 * (SQ_OUT_W - 1 - k)));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (SQ_OUT_W'(1) << (SQ_OUT_W - 1 - k));
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign root = root_reg[SQ_OUT_W-1];

endmodule
`default_nettype wire

### hw/rtl/aik_div.sv
`default_nettype none
module aik_div import aik_pkg::*;
(
    input  wire logic          clk,
    input  wire logic [DW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo
);

    // num <= den is required; quo = floor(num * 2^30 / den)
    logic [DW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [DW:0]   rem2;
        logic [DW-1:0] dv;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;
        logic [QW-1:0] quo_in;

        if (j == 0) begin : g_first
            assign rem2   = {1'b0, num};
            assign dv     = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem2   = {rem_reg[j-1], 1'b0};
            assign dv     = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign ge = rem2 >= {1'b0, dv};

        always_comb
        begin
            if (ge)
                rem_next = DW'(rem2 - {1'b0, dv});
            else
                rem_next = rem2[DW-1:0];
            quo_next = {quo_in[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            den_reg[j] <= dv;
            quo_reg[j] <= quo_next;
        end
    end

    assign quo = quo_reg[QW-1];

endmodule
`default_nettype wire

### hw/rtl/aik_cordic.sv
`default_nettype none
module aik_cordic import aik_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic signed [CW-1:0] y_in,
    input  wire logic signed [CW-1:0] x_in,
    output logic      signed [AW-1:0] ang
);

    logic signed [CW-1:0] x_reg    [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg    [CORDIC_STAGES+1];
    logic signed [AW-1:0] z_reg    [CORDIC_STAGES+1];
    logic                 zero_reg [CORDIC_STAGES+1];

    logic signed [CW-1:0] x0_next;
    logic signed [CW-1:0] y0_next;
    logic signed [AW-1:0] z0_next;

    // Fold the left half plane into the right one
    always_comb
    begin
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x0_next = y_in;
                y0_next = -x_in;
                z0_next = ANG_HALF_PI;
            end
            else
            begin
                x0_next = -y_in;
                y0_next = x_in;
                z0_next = -ANG_HALF_PI;
            end
        end
        else
        begin
            x0_next = x_in;
            y0_next = y_in;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        zero_reg[0] <= (x_in == 0) && (y_in == 0);
    end

    // Vectoring iterations, one per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [AW-1:0] at;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = $signed({3'b000, ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (!y_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - at;
            end
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    // The origin gives angle zero
    assign ang = zero_reg[CORDIC_STAGES] ? '0 : z_reg[CORDIC_STAGES];

endmodule
`default_nettype wire

### hw/rtl/arm_inverse_kinematics.sv
// Throughput: one request per cycle; busy stays low, so start is always taken.
// Latency is set by two 32-stage square roots, the 31-stage Q30 divider and
// the 17-stage CORDIC units in series. The receiver cannot stall the pipeline.
// Reset (rst_n low, asynchronous) drops all requests in flight and restores the
// link registers to 1600, 320 and 1600.
`default_nettype none
module arm_inverse_kinematics import aik_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] target_x,
    input  wire logic signed [15:0] target_y,
    input  wire logic signed [15:0] target_z,
    input  wire logic               hand_parallel,
    output logic                    done,
    output logic signed [16:0]      shoulder_yaw_angle,
    output logic signed [16:0]      shoulder_pitch_angle,
    output logic signed [16:0]      elbow_angle,
    output logic signed [16:0]      wrist_angle,
    output logic                    wrist_valid,
    output logic                    out_of_reach,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    // Pipeline positions, counted in registers after the accepting edge
    localparam int IDX_SQ1_IN   = 3;
    localparam int IDX_SQ1_OUT  = IDX_SQ1_IN + LAT_SQRT;
    localparam int IDX_DIV_IN   = IDX_SQ1_OUT + 1;
    localparam int IDX_DIV_OUT  = IDX_DIV_IN + LAT_DIV;
    localparam int IDX_Q2       = IDX_DIV_OUT + 1;
    localparam int IDX_DIFF     = IDX_Q2 + 1;
    localparam int IDX_SQ2_OUT  = IDX_DIFF + LAT_SQRT;
    localparam int IDX_CORD_OUT = IDX_SQ2_OUT + LAT_CORDIC;
    localparam int IDX_SUM      = IDX_CORD_OUT + 1;
    localparam int IDX_OUT      = IDX_SUM + 1;
    localparam int RXY_LEN      = IDX_SQ2_OUT - IDX_DIV_IN + 1;
    localparam int FLAG_LEN     = IDX_CORD_OUT - IDX_DIV_IN + 1;
    localparam int COS_LEN      = IDX_SQ2_OUT - IDX_Q2 + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [14:0] upper_reg;
    logic [14:0] middle_reg;
    logic [14:0] fore_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    // Write a link register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 15'd1600;
            middle_reg <= 15'd320;
            fore_reg   <= 15'd1600;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_UPPER:  upper_reg  <= pwdata[14:0];
                REG_MIDDLE: middle_reg <= pwdata[14:0];
                REG_FORE:   fore_reg   <= pwdata[14:0];
                default:    ;
            endcase
        end
    end

    // Read back a link register
    always_comb
    begin
        unique case (cfg_idx)
            REG_UPPER:  prdata = {17'd0, upper_reg};
            REG_MIDDLE: prdata = {17'd0, middle_reg};
            REG_FORE:   prdata = {17'd0, fore_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Valid chain and request delay line
    // ------------------------------------------------------------------
    logic  valid_reg [IDX_OUT+1];
    side_t side_reg  [IDX_CORD_OUT+1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= IDX_OUT; k++)
                valid_reg[k] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int k = 1; k <= IDX_OUT; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= '{x: target_x, y: target_y, z: target_z, hand: hand_parallel};
        for (int k = 1; k <= IDX_CORD_OUT; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // ------------------------------------------------------------------
    // Squares and sums of squares
    // ------------------------------------------------------------------
    logic signed [31:0] xsq_full;
    logic signed [31:0] ysq_full;
    logic signed [31:0] zsq_full;
    logic [30:0] xsq_reg;
    logic [30:0] ysq_reg;
    logic [30:0] zsq_reg;
    logic [29:0] asq_reg;
    logic [29:0] msq_reg;
    logic [29:0] fsq_reg;

    assign xsq_full = side_reg[0].x * side_reg[0].x;
    assign ysq_full = side_reg[0].y * side_reg[0].y;
    assign zsq_full = side_reg[0].z * side_reg[0].z;

    always_ff @(posedge clk)
    begin
        xsq_reg <= xsq_full[30:0];
        ysq_reg <= ysq_full[30:0];
        zsq_reg <= zsq_full[30:0];
        asq_reg <= upper_reg * upper_reg;
        msq_reg <= middle_reg * middle_reg;
        fsq_reg <= fore_reg * fore_reg;
    end

    logic [31:0] rxy2_reg;
    logic [31:0] r2_reg;
    logic [30:0] u2_reg;
    logic [29:0] f2_reg;

    always_ff @(posedge clk)
    begin
        rxy2_reg <= 32'(xsq_reg) + 32'(ysq_reg);
        r2_reg   <= 32'(xsq_reg) + 32'(ysq_reg) + 32'(zsq_reg);
        u2_reg   <= 31'(asq_reg) + 31'(msq_reg);
        f2_reg   <= fsq_reg;
    end

    // ------------------------------------------------------------------
    // Products and numerators, then the three square roots
    // ------------------------------------------------------------------
    logic [SQ_IN_W-1:0] rad_xy_reg;
    logic [SQ_IN_W-1:0] prod_t_reg;
    logic [SQ_IN_W-1:0] prod_a_reg;
    num_t               nd_reg [LAT_SQRT+1];
    logic signed [NW-1:0] u2_s;
    logic signed [NW-1:0] r2_s;
    logic signed [NW-1:0] f2_s;

    assign u2_s = $signed({4'd0, u2_reg});
    assign r2_s = $signed({3'd0, r2_reg});
    assign f2_s = $signed({5'd0, f2_reg});

    always_ff @(posedge clk)
    begin
        rad_xy_reg   <= {rxy2_reg, 32'd0};
        prod_t_reg   <= u2_reg * r2_reg;
        prod_a_reg   <= u2_reg * f2_reg;
        nd_reg[0].n_t <= u2_s + r2_s - f2_s;
        nd_reg[0].n_a <= u2_s - r2_s + f2_s;
        for (int k = 1; k <= LAT_SQRT; k++)
            nd_reg[k] <= nd_reg[k-1];
    end

    logic [SQ_OUT_W-1:0] rxy_root;
    logic [SQ_OUT_W-1:0] st_root;
    logic [SQ_OUT_W-1:0] sa_root;

    aik_isqrt u_sqrt_xy (.clk(clk), .rad(rad_xy_reg), .root(rxy_root));
    aik_isqrt u_sqrt_t  (.clk(clk), .rad(prod_t_reg), .root(st_root));
    aik_isqrt u_sqrt_a  (.clk(clk), .rad(prod_a_reg), .root(sa_root));

    // ------------------------------------------------------------------
    // Clamp the cosine arguments and divide
    // ------------------------------------------------------------------
    logic [DW-1:0] d_t;
    logic [DW-1:0] d_a;
    logic [NW-1:0] abs_t;
    logic [NW-1:0] abs_a;
    logic [DW-1:0] mag_t;
    logic [DW-1:0] mag_a;
    logic          clamp_t;
    logic          clamp_a;
    num_t          n_out;

    assign n_out   = nd_reg[LAT_SQRT];
    assign d_t     = {1'b0, st_root, 1'b0};
    assign d_a     = {1'b0, sa_root, 1'b0};
    assign abs_t   = n_out.n_t[NW-1] ? NW'(-n_out.n_t) : NW'(n_out.n_t);
    assign abs_a   = n_out.n_a[NW-1] ? NW'(-n_out.n_a) : NW'(n_out.n_a);
    assign mag_t   = abs_t[DW-1:0];
    assign mag_a   = abs_a[DW-1:0];
    assign clamp_t = (d_t == '0) || (mag_t > d_t);
    assign clamp_a = (d_a == '0) || (mag_a > d_a);

    logic [DW-1:0] num_t_reg;
    logic [DW-1:0] den_t_reg;
    logic [DW-1:0] num_a_reg;
    logic [DW-1:0] den_a_reg;
    sign_t         sg_reg   [LAT_DIV+1];
    logic          flag_reg [FLAG_LEN];
    logic [SQ_OUT_W-1:0] rxy_reg [RXY_LEN];

    // A clamped argument divides 1 by 1, which yields exactly one
    always_ff @(posedge clk)
    begin
        num_t_reg <= clamp_t ? DW'(1) : mag_t;
        den_t_reg <= clamp_t ? DW'(1) : d_t;
        num_a_reg <= clamp_a ? DW'(1) : mag_a;
        den_a_reg <= clamp_a ? DW'(1) : d_a;
        sg_reg[0] <= '{neg_t: n_out.n_t[NW-1], neg_a: n_out.n_a[NW-1]};
        flag_reg[0] <= clamp_t || clamp_a;
        rxy_reg[0]  <= rxy_root;
        for (int k = 1; k <= LAT_DIV; k++)
            sg_reg[k] <= sg_reg[k-1];
        for (int k = 1; k < FLAG_LEN; k++)
            flag_reg[k] <= flag_reg[k-1];
        for (int k = 1; k < RXY_LEN; k++)
            rxy_reg[k] <= rxy_reg[k-1];
    end

    logic [QW-1:0] q_t;
    logic [QW-1:0] q_a;

    aik_div u_div_t (.clk(clk), .num(num_t_reg), .den(den_t_reg), .quo(q_t));
    aik_div u_div_a (.clk(clk), .num(num_a_reg), .den(den_a_reg), .quo(q_a));

    // ------------------------------------------------------------------
    // Sine from cosine: sqrt(1 - c*c) in Q30
    // ------------------------------------------------------------------
    logic [2*QW-1:0]    qsq_t_reg;
    logic [2*QW-1:0]    qsq_a_reg;
    cos_t               c_reg [COS_LEN];
    logic signed [31:0] cq_t;
    logic signed [31:0] cq_a;

    assign cq_t = $signed({1'b0, q_t});
    assign cq_a = $signed({1'b0, q_a});

    always_ff @(posedge clk)
    begin
        qsq_t_reg <= q_t * q_t;
        qsq_a_reg <= q_a * q_a;
        c_reg[0].c_t <= sg_reg[LAT_DIV].neg_t ? -cq_t : cq_t;
        c_reg[0].c_a <= sg_reg[LAT_DIV].neg_a ? -cq_a : cq_a;
        for (int k = 1; k < COS_LEN; k++)
            c_reg[k] <= c_reg[k-1];
    end

    logic [SQ_IN_W-1:0] diff_t_reg;
    logic [SQ_IN_W-1:0] diff_a_reg;

    always_ff @(posedge clk)
    begin
        diff_t_reg <= Q60_ONE - SQ_IN_W'(qsq_t_reg);
        diff_a_reg <= Q60_ONE - SQ_IN_W'(qsq_a_reg);
    end

    logic [SQ_OUT_W-1:0] sn_t;
    logic [SQ_OUT_W-1:0] sn_a;

    aik_isqrt u_sqrt_sn_t (.clk(clk), .rad(diff_t_reg), .root(sn_t));
    aik_isqrt u_sqrt_sn_a (.clk(clk), .rad(diff_a_reg), .root(sn_a));

    // ------------------------------------------------------------------
    // Five atan2 units in parallel
    // ------------------------------------------------------------------
    side_t               sd;
    cos_t                cc;
    logic signed [CW-1:0] psi_y, psi_x, gam_y, gam_x, myu_y, myu_x;
    logic signed [CW-1:0] th_y, th_x, al_y, al_x;
    logic signed [AW-1:0] psi, gamma_ang, myu, theta, alpha;

    assign sd    = side_reg[IDX_SQ2_OUT];
    assign cc    = c_reg[COS_LEN-1];
    assign psi_y = {{(CW-32){sd.y[15]}}, sd.y, 16'h0000};
    assign psi_x = {{(CW-32){sd.x[15]}}, sd.x, 16'h0000};
    assign gam_y = {{(CW-32){sd.z[15]}}, sd.z, 16'h0000};
    assign gam_x = {{(CW-SQ_OUT_W){1'b0}}, rxy_reg[RXY_LEN-1]};
    assign myu_y = {{(CW-31){1'b0}}, middle_reg, 16'h0000};
    assign myu_x = {{(CW-31){1'b0}}, upper_reg, 16'h0000};
    assign th_y  = {{(CW-SQ_OUT_W){1'b0}}, sn_t};
    assign th_x  = {{(CW-32){cc.c_t[31]}}, cc.c_t};
    assign al_y  = {{(CW-SQ_OUT_W){1'b0}}, sn_a};
    assign al_x  = {{(CW-32){cc.c_a[31]}}, cc.c_a};

    aik_cordic u_cordic_psi   (.clk(clk), .y_in(psi_y), .x_in(psi_x), .ang(psi));
    aik_cordic u_cordic_gamma (.clk(clk), .y_in(gam_y), .x_in(gam_x), .ang(gamma_ang));
    aik_cordic u_cordic_myu   (.clk(clk), .y_in(myu_y), .x_in(myu_x), .ang(myu));
    aik_cordic u_cordic_theta (.clk(clk), .y_in(th_y),  .x_in(th_x),  .ang(theta));
    aik_cordic u_cordic_alpha (.clk(clk), .y_in(al_y),  .x_in(al_x),  .ang(alpha));

    // ------------------------------------------------------------------
    // Joint angle sums, then round and saturate
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] psi_s, gam_s, myu_s, th_s, al_s;
    logic signed [SUM_W-1:0] yaw_sum_reg, pitch_sum_reg, elbow_sum_reg, wrist_sum_reg;
    logic                    hand_sum_reg;
    logic                    flag_sum_reg;

    assign psi_s = SUM_W'(psi);
    assign gam_s = SUM_W'(gamma_ang);
    assign myu_s = SUM_W'(myu);
    assign th_s  = SUM_W'(theta);
    assign al_s  = SUM_W'(alpha);

    always_ff @(posedge clk)
    begin
        yaw_sum_reg   <= SUM_HALF_PI + psi_s;
        pitch_sum_reg <= gam_s + th_s + myu_s;
        elbow_sum_reg <= SUM_PI - al_s + myu_s;
        wrist_sum_reg <= al_s + gam_s + th_s + SUM_HALF_PI - myu_s - SUM_PI;
        hand_sum_reg  <= side_reg[IDX_CORD_OUT].hand;
        flag_sum_reg  <= flag_reg[FLAG_LEN-1];
    end

    logic signed [16:0] yaw_reg, pitch_reg, elbow_reg, wrist_reg;
    logic               wvalid_reg;
    logic               reach_reg;

    always_ff @(posedge clk)
    begin
        yaw_reg    <= finish_ang(yaw_sum_reg);
        pitch_reg  <= finish_ang(pitch_sum_reg);
        elbow_reg  <= finish_ang(elbow_sum_reg);
        wrist_reg  <= hand_sum_reg ? finish_ang(wrist_sum_reg) : '0;
        wvalid_reg <= hand_sum_reg;
        reach_reg  <= flag_sum_reg;
    end

    assign done                 = valid_reg[IDX_OUT];
    assign shoulder_yaw_angle   = yaw_reg;
    assign shoulder_pitch_angle = pitch_reg;
    assign elbow_angle          = elbow_reg;
    assign wrist_angle          = wrist_reg;
    assign wrist_valid          = wvalid_reg;
    assign out_of_reach         = reach_reg;

endmodule
`default_nettype wire
